FILE: rtl/mmc3_bank_irq_mapper_defines.svh
// Assertion macros shared by the mapper RTL.
`ifndef MMC3_BANK_IRQ_MAPPER_DEFINES_SVH
`define MMC3_BANK_IRQ_MAPPER_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Checked on every clock edge outside reset.
`define MMC3_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define MMC3_ASSERT_ANY(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MMC3_ASSERT(lbl, prop, msg)
`define MMC3_ASSERT_ANY(lbl, prop, msg)
`endif
`endif

FILE: rtl/mmc3_pkg.sv
// Types, codes and constants of the bank and IRQ mapper.
`default_nettype none
package mmc3_pkg;

	localparam int PADDR_W = 3;

	// Configuration register indexes (paddr bit 2).
	localparam logic REG_PRG_BANKS   = 1'b0;
	localparam logic REG_FOUR_SCREEN = 1'b1;

	localparam logic [8:0] PRG_BANKS_RESET = 9'd32;

	// Result kinds.
	localparam logic [1:0] KIND_PRG    = 2'd0;
	localparam logic [1:0] KIND_CHR    = 2'd1;
	localparam logic [1:0] KIND_MIRROR = 2'd2;
	localparam logic [1:0] KIND_IRQ    = 2'd3;

	// Decoded CPU register addresses.
	localparam logic [15:0] DECODE_MASK    = 16'hE001;
	localparam logic [15:0] CPU_SPACE_MIN  = 16'h8000;
	localparam logic [15:0] ADDR_BANK_SEL  = 16'h8000;
	localparam logic [15:0] ADDR_BANK_DATA = 16'h8001;
	localparam logic [15:0] ADDR_MIRROR    = 16'hA000;
	localparam logic [15:0] ADDR_IRQ_LATCH = 16'hC000;
	localparam logic [15:0] ADDR_IRQ_RELOAD = 16'hC001;
	localparam logic [15:0] ADDR_IRQ_OFF   = 16'hE000;
	localparam logic [15:0] ADDR_IRQ_ON    = 16'hE001;

	localparam logic [7:0] PRG_MODE_MASK = 8'h40;
	localparam logic [7:0] CHR_INV_MASK  = 8'h80;
	localparam logic [7:0] PAIR_MASK     = 8'hFE;
	localparam logic [7:0] SEL_MASK      = 8'h07;

	typedef struct packed {
		logic        cmd;
		logic [15:0] address;
		logic [7:0]  value;
		logic        in_vblank;
		logic        rendering_on;
	} req_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] slot;
		logic [7:0] bank;
		logic       last;
	} evt_t;

	typedef struct packed {
		logic [8:0] prg_banks;
		logic       four_screen;
	} cfg_t;

	typedef struct packed {
		logic [1:0] n;
		evt_t       e0;
		evt_t       e1;
	} core_out_t;

	function automatic evt_t mk_evt(logic [1:0] kind, logic [2:0] slot, logic [7:0] bank);
		evt_t e;
		e.kind = kind;
		e.slot = slot;
		e.bank = bank;
		e.last = 1'b0;
		return e;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/mmc3_if.sv
// Valid/ready channel interfaces for requests and mapper events.
`default_nettype none
interface mmc3_req_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [15:0] address;
	logic [7:0]  value;
	logic        in_vblank;
	logic        rendering_on;

	modport source(output valid, cmd, address, value, in_vblank, rendering_on, input ready);
	modport sink(input valid, cmd, address, value, in_vblank, rendering_on, output ready);
endinterface

interface mmc3_evt_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [2:0] slot;
	logic [7:0] bank;
	logic       last;

	modport source(output valid, kind, slot, bank, last, input ready);
	modport sink(input valid, kind, slot, bank, last, output ready);
endinterface
`default_nettype wire

FILE: rtl/mmc3_core.sv
// Mapper state and the event logic for one registered request.
`default_nettype none
module mmc3_core import mmc3_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  req_t      item,
	input  cfg_t      cfg,
	output core_out_t res
);

	logic [7:0] cmd_reg_q, cmd_reg_n;
	logic       prg_mode_q, prg_mode_n;
	logic [7:0] latch_q, latch_n;
	logic [8:0] counter_q, counter_n;
	logic       en_q, en_n;
	logic       reload_q, reload_n;

	always_comb begin
		logic [7:0]  fixed;
		logic [15:0] dec;
		logic [2:0]  sel;
		logic [2:0]  inv;
		logic [7:0]  pair;
		logic        mode;

		cmd_reg_n  = cmd_reg_q;
		prg_mode_n = prg_mode_q;
		latch_n    = latch_q;
		counter_n  = counter_q;
		en_n       = en_q;
		reload_n   = reload_q;
		res        = '0;

		fixed = cfg.prg_banks[7:0] - 8'd2;
		dec   = item.address & DECODE_MASK;
		sel   = cmd_reg_q[2:0] & SEL_MASK[2:0];
		inv   = {((cmd_reg_q & CHR_INV_MASK) != 8'd0), 2'b00};
		pair  = item.value & PAIR_MASK;
		mode  = (item.value & PRG_MODE_MASK) != 8'd0;

		if (!item.cmd) begin
			if (item.address >= CPU_SPACE_MIN) begin
				unique case (dec)
					ADDR_BANK_SEL: begin
						cmd_reg_n  = item.value;
						prg_mode_n = mode;
						if (prg_mode_q != mode) begin
							res.e0 = mk_evt(KIND_PRG, mode ? 3'd0 : 3'd2, fixed);
							res.n  = 2'd1;
						end
					end
					ADDR_BANK_DATA: begin
						priority if (sel <= 3'd1) begin
							res.e0 = mk_evt(KIND_CHR, {1'b0, sel[0], 1'b0} ^ inv, pair);
							res.e1 = mk_evt(KIND_CHR, {1'b0, sel[0], 1'b1} ^ inv,
								pair | 8'd1);
							res.n  = 2'd2;
						end else if (sel <= 3'd5) begin
							res.e0 = mk_evt(KIND_CHR, (sel + 3'd2) ^ inv, item.value);
							res.n  = 2'd1;
						end else if (sel == 3'd6) begin
							res.e0 = mk_evt(KIND_PRG,
								((cmd_reg_q & PRG_MODE_MASK) != 8'd0) ? 3'd2 : 3'd0,
								item.value);
							res.n  = 2'd1;
						end else begin
							res.e0 = mk_evt(KIND_PRG, 3'd1, item.value);
							res.n  = 2'd1;
						end
					end
					ADDR_MIRROR: begin
						if (!cfg.four_screen) begin
							res.e0 = mk_evt(KIND_MIRROR, 3'd0, {7'd0, item.value[0]});
							res.n  = 2'd1;
						end
					end
					ADDR_IRQ_LATCH: latch_n = item.value;
					ADDR_IRQ_RELOAD: begin
						reload_n  = 1'b1;
						counter_n = {1'b0, latch_q};
					end
					ADDR_IRQ_OFF: en_n = 1'b0;
					ADDR_IRQ_ON: en_n = 1'b1;
					default: ;
				endcase
				// A pending reload reloads the counter after every write.
				if (reload_n) begin
					counter_n = {1'b0, latch_n};
				end
			end
		end else if (!item.in_vblank && item.rendering_on && !counter_q[8]) begin
			// The counter sticks at -1 until a write reloads it.
			reload_n  = 1'b0;
			counter_n = counter_q - 9'd1;
			if (counter_q == 9'd0 && en_q) begin
				reload_n = 1'b1;
				res.e0   = mk_evt(KIND_IRQ, 3'd0, 8'd0);
				res.n    = 2'd1;
			end
		end

		if (res.n == 2'd1) begin
			res.e0.last = 1'b1;
		end
		if (res.n == 2'd2) begin
			res.e1.last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_reg_q  <= '0;
			prg_mode_q <= 1'b0;
			latch_q    <= '0;
			counter_q  <= '0;
			en_q       <= 1'b0;
			reload_q   <= 1'b0;
		end else if (fire) begin
			cmd_reg_q  <= cmd_reg_n;
			prg_mode_q <= prg_mode_n;
			latch_q    <= latch_n;
			counter_q  <= counter_n;
			en_q       <= en_n;
			reload_q   <= reload_n;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/mmc3_bank_irq_mapper.sv
// Top level of the bank and IRQ mapper: register port, request stage and event queue.
//
//  channel | role   | payload                                  | handshake
//  req     | sink   | cmd, address, value, in_vblank, rend_on | valid & ready
//  evt     | source | kind, slot, bank, last                   | valid & ready
//  apb     | slave  | paddr[2:0], pwdata/prdata 32 bits        | psel & penable
//
// A request is registered in the request stage, then its events are formed in one pass
// and registered into a two-entry event queue, whose head entry is offered on evt.
// Requests with at most one event can be accepted every cycle while evt keeps up;
// one with two events needs the queue empty and fills both entries.
// Reset clears the mapper state, the stage and the queue at once; no clearing pass.
// A stalled evt channel holds the request stage, and req.ready drops behind it.
`default_nettype none
`include "mmc3_bank_irq_mapper_defines.svh"
module mmc3_bank_irq_mapper import mmc3_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	mmc3_req_if.sink           req,
	mmc3_evt_if.source         evt
);

	cfg_t      cfg_q;
	logic      valid_s1;
	req_t      req_s1;
	evt_t      evq_q [2];
	logic [1:0] cnt_q;
	core_out_t core_res;

	logic       pop;
	logic       adv;
	logic [1:0] rem;
	logic [1:0] free;
	evt_t       evq_n [2];
	logic [1:0] cnt_n;

	// Register port.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prg_banks   <= PRG_BANKS_RESET;
			cfg_q.four_screen <= 1'b0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_PRG_BANKS:   cfg_q.prg_banks   <= pwdata[8:0];
				REG_FOUR_SCREEN: cfg_q.four_screen <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_PRG_BANKS:   prdata = {23'd0, cfg_q.prg_banks};
			REG_FOUR_SCREEN: prdata = {31'd0, cfg_q.four_screen};
			default:         prdata = '0;
		endcase
	end

	// Event queue bookkeeping.
	assign pop  = evt.valid && evt.ready;
	assign rem  = cnt_q - {1'b0, pop};
	assign free = 2'd2 - rem;
	assign adv  = valid_s1 && (core_res.n <= free);

	assign req.ready = !valid_s1 || adv;

	mmc3_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (adv),
		.item   (req_s1),
		.cfg    (cfg_q),
		.res    (core_res)
	);

	always_comb begin
		evq_n[0] = pop ? evq_q[1] : evq_q[0];
		evq_n[1] = evq_q[1];
		if (adv) begin
			if (rem == 2'd0) begin
				evq_n[0] = core_res.e0;
				evq_n[1] = core_res.e1;
			end else if (rem == 2'd1) begin
				evq_n[1] = core_res.e0;
			end
		end
		cnt_n = rem + (adv ? core_res.n : 2'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cnt_q    <= '0;
		end else begin
			cnt_q <= cnt_n;
			if (req.valid && req.ready) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1.cmd          <= req.cmd;
			req_s1.address      <= req.address;
			req_s1.value        <= req.value;
			req_s1.in_vblank    <= req.in_vblank;
			req_s1.rendering_on <= req.rendering_on;
		end
		evq_q[0] <= evq_n[0];
		evq_q[1] <= evq_n[1];
	end

	assign evt.valid = cnt_q != 2'd0;
	assign evt.kind  = evq_q[0].kind;
	assign evt.slot  = evq_q[0].slot;
	assign evt.bank  = evq_q[0].bank;
	assign evt.last  = evq_q[0].last;

	`MMC3_ASSERT(a_s1_hold, valid_s1 && !adv |=> valid_s1 && $stable(req_s1), "held request lost")
	`MMC3_ASSERT(a_pair_room, adv && core_res.n == 2'd2 |-> rem == 2'd0, "pair into busy queue")
	`MMC3_ASSERT(a_irq_last, evt.valid && evt.kind == KIND_IRQ |-> evt.last, "IRQ event not last")
	`MMC3_ASSERT_ANY(a_rst_quiet, !arst_n |=> !evt.valid, "event offered right after reset")

endmodule
`default_nettype wire

FILE: bench/tb_top.sv
// Self-checking testbench of the bank and IRQ mapper: directed table, random requests, APB.
module tb_top import mmc3_pkg::*; ();

	localparam int CLK_PERIOD        = 12;
	localparam int RESET_CYCLES      = 7;
	localparam int NUM_SETTINGS      = 7;
	localparam int ITEMS_PER_SETTING = 165;
	localparam int LONG_HOLD         = 400;
	localparam int DRAIN_CYCLES      = 12;
	localparam int TIMEOUT_CYCLES    = 400000;
	localparam int PREDICT           = -1;
	localparam evt_t NO_EVENT        = '0;

	typedef struct {
		req_t r;
		int   n;
		evt_t e0;
		evt_t e1;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	mmc3_req_if req_ch();
	mmc3_evt_if evt_ch();

	mmc3_bank_irq_mapper dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req_ch),
		.evt     (evt_ch)
	);

	// Mirror of the mapper state and its two settings.
	logic [8:0] prg_banks;
	logic       four_scr;
	logic [7:0] cmd_reg;
	logic       prg_mode;
	logic [7:0] irq_latch;
	int         irq_count;
	logic       irq_en;
	logic       reload_flag;

	evt_t     expected_events[$];
	evt_t     new_events[$];
	req_t     stim_q[$];
	dir_row_t dir_rows[$];

	int errors = 0;
	int req_count = 0;
	int event_count = 0;
	int burst_left = 1;
	int hold_ticket = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int rx_mode = 0;
	int mode_left = 0;
	logic [7:0] stall_pat = 8'hFF;

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("FAILED: results differ");
		$finish;
	end

	function automatic evt_t make_event(input logic [1:0] k, input logic [2:0] s,
			input logic [7:0] b);
		evt_t e;
		e.kind = k;
		e.slot = s;
		e.bank = b;
		e.last = 1'b0;
		return e;
	endfunction

	function automatic logic [2:0] chr_slot_of(input logic [2:0] s);
		return ((cmd_reg & CHR_INV_MASK) != 8'd0) ? (s ^ 3'd4) : s;
	endfunction

	// Updates the mirrored state for one request and leaves its events in new_events.
	function automatic void map_request(input req_t r);
		logic [8:0] fixed_wide;
		logic [7:0] fixed_bank;
		logic [7:0] pair;
		logic [2:0] sel;
		logic       new_mode;
		evt_t       tail;
		new_events.delete();
		fixed_wide = prg_banks - 9'd2;
		fixed_bank = fixed_wide[7:0];
		if (!r.cmd) begin
			if (r.address >= CPU_SPACE_MIN) begin
				case (r.address & DECODE_MASK)
					ADDR_BANK_SEL: begin
						new_mode = (r.value & PRG_MODE_MASK) != 8'd0;
						cmd_reg = r.value;
						// Only the fixed bank moves when the PRG mode flips.
						if (new_mode != prg_mode)
							new_events.push_back(make_event(KIND_PRG,
								new_mode ? 3'd0 : 3'd2, fixed_bank));
						prg_mode = new_mode;
					end
					ADDR_BANK_DATA: begin
						sel = cmd_reg[2:0];
						if (sel <= 3'd1) begin
							pair = r.value & PAIR_MASK;
							new_events.push_back(make_event(KIND_CHR,
								chr_slot_of({sel[1:0], 1'b0}), pair));
							new_events.push_back(make_event(KIND_CHR,
								chr_slot_of({sel[1:0], 1'b1}), pair + 8'd1));
						end else if (sel <= 3'd5) begin
							new_events.push_back(make_event(KIND_CHR,
								chr_slot_of(sel + 3'd2), r.value));
						end else if (sel == 3'd6) begin
							new_events.push_back(make_event(KIND_PRG,
								((cmd_reg & PRG_MODE_MASK) != 8'd0) ? 3'd2 : 3'd0,
								r.value));
						end else begin
							new_events.push_back(make_event(KIND_PRG, 3'd1, r.value));
						end
					end
					ADDR_MIRROR: begin
						if (!four_scr)
							new_events.push_back(make_event(KIND_MIRROR, 3'd0,
								{7'd0, r.value[0]}));
					end
					ADDR_IRQ_LATCH: irq_latch = r.value;
					ADDR_IRQ_RELOAD: begin
						reload_flag = 1'b1;
						irq_count = int'(irq_latch);
					end
					ADDR_IRQ_OFF: irq_en = 1'b0;
					ADDR_IRQ_ON: irq_en = 1'b1;
					default: ;
				endcase
				// A pending reload keeps copying the latch after every write.
				if (reload_flag)
					irq_count = int'(irq_latch);
			end
		end else if (!r.in_vblank && r.rendering_on && irq_count >= 0) begin
			reload_flag = 1'b0;
			irq_count = irq_count - 1;
			if (irq_count < 0 && irq_en) begin
				reload_flag = 1'b1;
				new_events.push_back(make_event(KIND_IRQ, 3'd0, 8'd0));
			end
		end
		if (new_events.size() > 0) begin
			tail = new_events.pop_back();
			tail.last = 1'b1;
			new_events.push_back(tail);
		end
	endfunction

	function automatic req_t wr_item(input logic [15:0] a, input logic [7:0] v);
		req_t x;
		x.cmd = 1'b0;
		x.address = a;
		x.value = v;
		x.in_vblank = 1'($urandom_range(0, 1));
		x.rendering_on = 1'($urandom_range(0, 1));
		return x;
	endfunction

	function automatic req_t tick_item(input logic vb, input logic ro);
		req_t x;
		x.cmd = 1'b1;
		x.address = 16'($urandom_range(0, 65535));
		x.value = 8'($urandom_range(0, 255));
		x.in_vblank = vb;
		x.rendering_on = ro;
		return x;
	endfunction

	// Random address that decodes to the given register.
	function automatic logic [15:0] alias_of(input logic [15:0] base);
		logic [15:0] noise;
		noise = 16'($urandom_range(0, 65535));
		return base | (noise & ~DECODE_MASK);
	endfunction

	function automatic void add_row(input req_t r, input int n, input evt_t e0, input evt_t e1);
		dir_row_t row;
		row.r = r;
		row.n = n;
		row.e0 = e0;
		row.e1 = e1;
		dir_rows.push_back(row);
	endfunction

	// Mostly well-formed register sequences and active scanline runs, some noise.
	task automatic fill_sequence();
		int pick;
		int i;
		int runlen;
		logic [7:0] lat;
		req_t x;
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			stim_q.push_back(wr_item(alias_of(ADDR_BANK_SEL), 8'($urandom_range(0, 255))));
			runlen = $urandom_range(1, 2);
			for (i = 0; i < runlen; i++)
				stim_q.push_back(wr_item(alias_of(ADDR_BANK_DATA),
					8'($urandom_range(0, 255))));
		end else if (pick < 45) begin
			stim_q.push_back(wr_item(alias_of(ADDR_MIRROR), 8'($urandom_range(0, 255))));
		end else if (pick < 60) begin
			lat = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) :
				8'($urandom_range(0, 6));
			stim_q.push_back(wr_item(alias_of(ADDR_IRQ_LATCH), lat));
			stim_q.push_back(wr_item(alias_of(ADDR_IRQ_RELOAD), 8'($urandom_range(0, 255))));
			stim_q.push_back(wr_item(alias_of(($urandom_range(0, 3) == 0) ?
				ADDR_IRQ_OFF : ADDR_IRQ_ON), 8'($urandom_range(0, 255))));
			runlen = (lat < 8'd8) ? lat + 2 : $urandom_range(1, 12);
			for (i = 0; i < runlen; i++)
				stim_q.push_back(tick_item($urandom_range(0, 9) == 0,
					$urandom_range(0, 9) != 0));
		end else if (pick < 80) begin
			runlen = $urandom_range(1, 12);
			for (i = 0; i < runlen; i++)
				stim_q.push_back(tick_item($urandom_range(0, 5) == 0,
					$urandom_range(0, 5) != 0));
		end else if (pick < 90) begin
			stim_q.push_back(wr_item({1'b1, 15'($urandom_range(0, 32767))},
				8'($urandom_range(0, 255))));
		end else begin
			x.cmd = 1'($urandom_range(0, 1));
			x.address = 16'($urandom_range(0, 65535));
			x.value = 8'($urandom_range(0, 255));
			x.in_vblank = 1'($urandom_range(0, 1));
			x.rendering_on = 1'($urandom_range(0, 1));
			stim_q.push_back(x);
		end
	endtask

	// Offers one request, records what it should produce, then maybe idles.
	task automatic send_req(input req_t r, input int typed_n, input evt_t t0, input evt_t t1);
		int gap;
		req_ch.valid <= 1'b1;
		req_ch.cmd <= r.cmd;
		req_ch.address <= r.address;
		req_ch.value <= r.value;
		req_ch.in_vblank <= r.in_vblank;
		req_ch.rendering_on <= r.rendering_on;
		do @(posedge clk); while (!req_ch.ready);
		req_count++;
		map_request(r);
		if (typed_n == PREDICT) begin
			foreach (new_events[i])
				expected_events.push_back(new_events[i]);
		end else begin
			if (typed_n > 0) begin
				t0.last = (typed_n == 1);
				expected_events.push_back(t0);
			end
			if (typed_n > 1) begin
				t1.last = 1'b1;
				expected_events.push_back(t1);
			end
		end
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) :
				$urandom_range(1, 16);
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Requests that map nothing may still be in flight once the queue is empty.
	task automatic drain();
		req_ch.valid <= 1'b0;
		wait (expected_events.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input logic idx, input logic [31:0] data);
		logic [31:0] stored;
		stored = (idx == REG_PRG_BANKS) ? (data & 32'h1FF) : (data & 32'h1);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		if (idx == REG_PRG_BANKS)
			prg_banks = data[8:0];
		else
			four_scr = data[0];
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== stored) begin
			$error("prdata: expected %0d, got %0d", stored, prdata);
			errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Receiver: changing stall patterns, plain stretches, and one long hold-off on request.
	always @(posedge clk) begin
		if (hold_ticket != hold_seen) begin
			hold_seen = hold_ticket;
			hold_left = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			evt_ch.ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				rx_mode = $urandom_range(0, 2);
				mode_left = $urandom_range(16, 96);
				stall_pat = 8'($urandom_range(0, 255));
			end
			mode_left--;
			stall_pat = {stall_pat[6:0], stall_pat[7]};
			case (rx_mode)
				0: evt_ch.ready <= 1'b1;
				1: evt_ch.ready <= stall_pat[0];
				default: evt_ch.ready <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	always @(posedge clk) begin : event_check
		evt_t want;
		if (arst_n && evt_ch.valid && evt_ch.ready) begin
			if (expected_events.size() == 0) begin
				$error("unexpected event: kind %0d slot %0d bank %0d last %0d",
					evt_ch.kind, evt_ch.slot, evt_ch.bank, evt_ch.last);
				errors++;
			end else begin
				want = expected_events.pop_front();
				event_count++;
				if (evt_ch.kind !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, evt_ch.kind);
					errors++;
				end
				if (evt_ch.slot !== want.slot) begin
					$error("slot: expected %0d, got %0d", want.slot, evt_ch.slot);
					errors++;
				end
				if (evt_ch.bank !== want.bank) begin
					$error("bank: expected %0d, got %0d", want.bank, evt_ch.bank);
					errors++;
				end
				if (evt_ch.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, evt_ch.last);
					errors++;
				end
			end
		end
	end

	initial begin
		int ph;
		int sent;
		logic [8:0] nb;
		logic fs;
		logic paused;
		req_t r;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.cmd = 1'b0;
		req_ch.address = '0;
		req_ch.value = '0;
		req_ch.in_vblank = 1'b0;
		req_ch.rendering_on = 1'b0;
		evt_ch.ready = 1'b0;
		prg_banks = PRG_BANKS_RESET;
		four_scr = 1'b0;
		cmd_reg = '0;
		prg_mode = 1'b0;
		irq_latch = '0;
		irq_count = 0;
		irq_en = 1'b0;
		reload_flag = 1'b0;
		paused = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests at the reset settings; the fixed bank is 30 here.
		add_row(tick_item(1'b0, 1'b1), 0, NO_EVENT, NO_EVENT);
		add_row(tick_item(1'b0, 1'b1), 0, NO_EVENT, NO_EVENT);
		add_row(wr_item(CPU_SPACE_MIN - 16'd1, 8'hFF), 0, NO_EVENT, NO_EVENT);
		add_row(wr_item(ADDR_BANK_SEL, PRG_MODE_MASK), 1,
			make_event(KIND_PRG, 3'd0, 8'd30), NO_EVENT);
		add_row(wr_item(ADDR_BANK_SEL, 8'h46), 0, NO_EVENT, NO_EVENT);
		add_row(wr_item(ADDR_BANK_DATA, 8'hAB), 1,
			make_event(KIND_PRG, 3'd2, 8'hAB), NO_EVENT);
		add_row(wr_item(ADDR_BANK_SEL, 8'h07), 1,
			make_event(KIND_PRG, 3'd2, 8'd30), NO_EVENT);
		add_row(wr_item(ADDR_BANK_DATA, 8'hFF), 1,
			make_event(KIND_PRG, 3'd1, 8'hFF), NO_EVENT);
		add_row(wr_item(ADDR_BANK_SEL, 8'h00), 0, NO_EVENT, NO_EVENT);
		add_row(wr_item(ADDR_BANK_DATA, 8'hFF), 2,
			make_event(KIND_CHR, 3'd0, 8'hFE), make_event(KIND_CHR, 3'd1, 8'hFF));
		add_row(wr_item(ADDR_BANK_SEL, 8'h81), 0, NO_EVENT, NO_EVENT);
		add_row(wr_item(ADDR_BANK_DATA, 8'h00), PREDICT, NO_EVENT, NO_EVENT);
		add_row(wr_item(ADDR_BANK_SEL, 8'hC5), PREDICT, NO_EVENT, NO_EVENT);
		add_row(wr_item(ADDR_BANK_DATA, 8'h12), PREDICT, NO_EVENT, NO_EVENT);
		add_row(wr_item(ADDR_BANK_SEL | 16'h1FFE, 8'h06), PREDICT, NO_EVENT, NO_EVENT);
		add_row(wr_item(ADDR_MIRROR, 8'h01), 1,
			make_event(KIND_MIRROR, 3'd0, 8'd1), NO_EVENT);
		add_row(wr_item(ADDR_MIRROR | 16'h0001, 8'hFF), 0, NO_EVENT, NO_EVENT);
		add_row(wr_item(ADDR_IRQ_LATCH, 8'h02), 0, NO_EVENT, NO_EVENT);
		add_row(wr_item(ADDR_IRQ_RELOAD, 8'h00), 0, NO_EVENT, NO_EVENT);
		add_row(wr_item(ADDR_IRQ_ON, 8'h00), 0, NO_EVENT, NO_EVENT);
		add_row(tick_item(1'b0, 1'b1), 0, NO_EVENT, NO_EVENT);
		add_row(tick_item(1'b1, 1'b1), 0, NO_EVENT, NO_EVENT);
		add_row(tick_item(1'b0, 1'b0), 0, NO_EVENT, NO_EVENT);
		add_row(tick_item(1'b0, 1'b1), 0, NO_EVENT, NO_EVENT);
		add_row(tick_item(1'b0, 1'b1), 1, make_event(KIND_IRQ, 3'd0, 8'd0), NO_EVENT);
		add_row(wr_item(ADDR_IRQ_OFF, 8'h00), 0, NO_EVENT, NO_EVENT);
		foreach (dir_rows[i])
			send_req(dir_rows[i].r, dir_rows[i].n, dir_rows[i].e0, dir_rows[i].e1);
		drain();

		for (ph = 0; ph < NUM_SETTINGS; ph++) begin
			case (ph)
				0: begin nb = 9'd32;  fs = 1'b0; end
				1: begin nb = 9'd2;   fs = 1'b1; end
				2: begin nb = 9'd256; fs = 1'b0; end
				3: begin nb = 9'd1;   fs = 1'b1; end
				4: begin nb = 9'd0;   fs = 1'b0; end
				5: begin nb = 9'd511; fs = 1'b1; end
				default: begin
					nb = 9'($urandom_range(2, 256));
					fs = 1'($urandom_range(0, 1));
				end
			endcase
			reg_write(REG_PRG_BANKS, {23'd0, nb});
			reg_write(REG_FOUR_SCREEN, {31'd0, fs});
			// The receiver holds off while requests keep coming, so the input backs up.
			if (ph == 1)
				hold_ticket++;
			sent = 0;
			while (sent < ITEMS_PER_SETTING) begin
				if (stim_q.size() == 0)
					fill_sequence();
				r = stim_q.pop_front();
				send_req(r, PREDICT, NO_EVENT, NO_EVENT);
				if (r.cmd || r.address >= CPU_SPACE_MIN)
					sent++;
				if (ph == 3 && sent >= 80 && !paused) begin
					paused = 1'b1;
					drain();
				end
			end
			drain();
		end

		$display("Summary: %0d requests, %0d events compared, %0d register settings",
			req_count, event_count, NUM_SETTINGS + 1);
		$display("Bank counts from 0 to 511 with and without four-screen, one long output stall.");
		if (errors == 0 && expected_events.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
